FILE: rtl/core/secded_pkg.sv
// Package: types, masks and helper functions for the SECDED 16/11 codec.
`timescale 1ns / 1ps

package secded_pkg;

  localparam int unsigned CwWidth   = 16;
  localparam int unsigned DataWidth = 11;
  localparam int unsigned SynWidth  = 5;

  // Check groups over codeword bit positions
  localparam logic [CwWidth-1:0] Group0Mask = 16'h007F;
  localparam logic [CwWidth-1:0] Group1Mask = 16'h070F;
  localparam logic [CwWidth-1:0] Group2Mask = 16'h1333;
  localparam logic [CwWidth-1:0] Group3Mask = 16'h1555;
  localparam logic [CwWidth-1:0] AllButTop  = 16'h7FFF;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_DOUBLE    = 2'd2
  } status_e;

  typedef struct packed {
    logic [CwWidth-1:0]   codeword;
    logic [DataWidth-1:0] data;
    logic [SynWidth-1:0]  syndrome;
    status_e              status;
  } result_t;

  function automatic logic [DataWidth-1:0] extract_data(input logic [CwWidth-1:0] cw);
    return {cw[12], cw[10:8], cw[6:0]};
  endfunction

endpackage

FILE: rtl/core/secded_16_11_codec_core.sv
// Top level: input register, encode/decode logic, result register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | opcode_i, word_in_i
//   out     | output    | out_valid_o / out_ready_i| codeword_out_o, data_out_o, syndrome_o,
//           |           |                         | status_o
//
// One transaction per cycle while out_ready_i is high; an accepted transaction passes
// through the input register and then the result register before it shows at out.
// Reset clears both stage valid flags; payload registers are not reset.
// A stalled result holds in the result register while the input register still
// takes a new transaction; both full and out_ready_i low drops in_ready_o.
`timescale 1ns / 1ps

module secded_16_11_codec_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [secded_pkg::CwWidth-1:0]    word_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [secded_pkg::CwWidth-1:0]    codeword_out_o,
  output logic [secded_pkg::DataWidth-1:0]  data_out_o,
  output logic [secded_pkg::SynWidth-1:0]   syndrome_o,
  output logic [1:0]                        status_o
);
  import secded_pkg::*;

  logic               s1_valid_q, s1_valid_d;
  op_e                s1_op_q;
  logic [CwWidth-1:0] s1_word_q;
  logic               s2_valid_q, s2_valid_d;
  result_t            s2_res_q, s2_res_d;
  result_t            enc_res, dec_res;
  logic               s2_free, s2_load, in_fire;

  secded_enc u_enc (
    .data_i (s1_word_q[DataWidth-1:0]),
    .res_o  (enc_res)
  );

  secded_dec u_dec (
    .word_i (s1_word_q),
    .res_o  (dec_res)
  );

  assign s2_free    = !s2_valid_q || out_ready_i;
  assign s2_load    = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;
    s2_valid_d = s2_free ? s1_valid_q : s2_valid_q;
    s2_res_d   = (s1_op_q == OP_DECODE) ? dec_res : enc_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= op_e'(opcode_i);
      s1_word_q <= word_in_i;
    end
    if (s2_load) begin
      s2_res_q <= s2_res_d;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign codeword_out_o = s2_res_q.codeword;
  assign data_out_o     = s2_res_q.data;
  assign syndrome_o     = s2_res_q.syndrome;
  assign status_o       = s2_res_q.status;

endmodule

FILE: rtl/core/secded_enc.sv
// Encoder: spreads 11 data bits and adds four check bits plus overall parity.
`timescale 1ns / 1ps

module secded_enc (
  input  logic [secded_pkg::DataWidth-1:0] data_i,
  output secded_pkg::result_t              res_o
);
  import secded_pkg::*;

  logic [CwWidth-1:0] base;
  logic [CwWidth-1:0] cw;

  always_comb begin
    base       = '0;
    base[6:0]  = data_i[6:0];
    base[8]    = data_i[7];
    base[10:9] = data_i[9:8];
    base[12]   = data_i[10];
    cw         = base;
    cw[7]      = ^(base & Group0Mask);
    cw[11]     = ^(base & Group1Mask);
    cw[13]     = ^(base & Group2Mask);
    cw[14]     = ^(base & Group3Mask);
    cw[15]     = ^(cw & AllButTop);
  end

  assign res_o.codeword = cw;
  assign res_o.data     = data_i;
  assign res_o.syndrome = '0;
  assign res_o.status   = ST_NONE;

endmodule

FILE: rtl/core/secded_dec.sv
// Decoder: syndrome, single-bit correction and data extraction.
`timescale 1ns / 1ps

module secded_dec (
  input  logic [secded_pkg::CwWidth-1:0] word_i,
  output secded_pkg::result_t            res_o
);
  import secded_pkg::*;

  logic [SynWidth-1:0] syn;
  logic [3:0]          pos;
  logic [CwWidth-1:0]  flip;
  logic [CwWidth-1:0]  cw;
  status_e             status;

  always_comb begin
    syn[0] = ^(word_i & Group0Mask) ^ word_i[7];
    syn[1] = ^(word_i & Group1Mask) ^ word_i[11];
    syn[2] = ^(word_i & Group2Mask) ^ word_i[13];
    syn[3] = ^(word_i & Group3Mask) ^ word_i[14];
    syn[4] = ^word_i;
    // Bad bit sits at 15 minus the check syndrome (bit-reversed)
    pos    = ~{syn[0], syn[1], syn[2], syn[3]};
    flip   = CwWidth'(1) << pos;
    cw     = word_i;
    status = ST_NONE;
    if (syn[4]) begin
      cw     = word_i ^ flip;
      status = ST_CORRECTED;
    end else if (syn[3:0] != '0) begin
      status = ST_DOUBLE;
    end
  end

  assign res_o.codeword = cw;
  assign res_o.data     = extract_data(cw);
  assign res_o.syndrome = syn;
  assign res_o.status   = status;

endmodule

FILE: rtl/core/secded_checker.sv
// Checker: port-level properties of the codec, bound to the top level.
`timescale 1ns / 1ps

module secded_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [secded_pkg::CwWidth-1:0]    codeword_out_o,
  input logic [secded_pkg::DataWidth-1:0]  data_out_o,
  input logic [secded_pkg::SynWidth-1:0]   syndrome_o,
  input logic [1:0]                        status_o
);
  import secded_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(codeword_out_o)
      && $stable(data_out_o) && $stable(syndrome_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Data field always matches the codeword it came from
  a_data_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> data_out_o == extract_data(codeword_out_o))
    else $error("data_out does not match codeword_out");

  // Overall parity mismatch means a correction was made
  a_corrected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && syndrome_o[4] |-> status_o == ST_CORRECTED)
    else $error("overall mismatch without correction");

  // Clean syndrome means no error and an even-parity codeword
  a_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && syndrome_o == '0 |-> status_o == ST_NONE && !(^codeword_out_o))
    else $error("clean syndrome with error status or odd codeword");

  // Check mismatch with matching overall parity is a double error
  a_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !syndrome_o[4] && syndrome_o[3:0] != '0 |-> status_o == ST_DOUBLE)
    else $error("double error not flagged");

endmodule

bind secded_16_11_codec_core secded_checker u_secded_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .codeword_out_o (codeword_out_o),
  .data_out_o     (data_out_o),
  .syndrome_o     (syndrome_o),
  .status_o       (status_o)
);

FILE: dv/tb_top.sv
// Testbench for the SECDED 16/11 codec core: directed and random encode/decode traffic.
`timescale 1ns / 1ps

module tb_top;
  import secded_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Parity group covers, one per check bit
  localparam logic [15:0] CHK0_COVER = 16'h007F;
  localparam logic [15:0] CHK1_COVER = 16'h070F;
  localparam logic [15:0] CHK2_COVER = 16'h1333;
  localparam logic [15:0] CHK3_COVER = 16'h1555;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [15:0] word_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] codeword_out_o;
  logic [10:0] data_out_o;
  logic [4:0]  syndrome_o;
  logic [1:0]  status_o;

  result_t     expected_results[$];
  logic        bursts_on;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  int unsigned n_encode;
  int unsigned n_decode;
  int unsigned n_checked;
  int unsigned n_corrected;
  int unsigned n_double;

  secded_16_11_codec_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .word_in_i      (word_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .codeword_out_o (codeword_out_o),
    .data_out_o     (data_out_o),
    .syndrome_o     (syndrome_o),
    .status_o       (status_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [15:0] encode_secded(logic [10:0] data);
    logic [15:0] cw;
    cw = {3'b000, data[10], 1'b0, data[9:7], 1'b0, data[6:0]};
    cw[7]  = ^(cw & CHK0_COVER);
    cw[11] = ^(cw & CHK1_COVER);
    cw[13] = ^(cw & CHK2_COVER);
    cw[14] = ^(cw & CHK3_COVER);
    cw[15] = ^cw[14:0];
    return cw;
  endfunction

  function automatic result_t predict_codec_result(op_e op, logic [15:0] w);
    result_t     res;
    logic [15:0] cw;
    logic [4:0]  syn;
    logic [3:0]  pos;
    syn = '0;
    res.status = ST_NONE;
    if (op == OP_ENCODE) begin
      cw = encode_secded(w[10:0]);
    end else begin
      cw = w;
      syn[0] = ^(w & CHK0_COVER) ^ w[7];
      syn[1] = ^(w & CHK1_COVER) ^ w[11];
      syn[2] = ^(w & CHK2_COVER) ^ w[13];
      syn[3] = ^(w & CHK3_COVER) ^ w[14];
      syn[4] = ^w[14:0] ^ w[15];
      if (syn[4]) begin
        pos = {~syn[0], ~syn[1], ~syn[2], ~syn[3]};
        cw[pos] = ~cw[pos];
        res.status = ST_CORRECTED;
      end else if (syn[3:0] != 4'd0) begin
        res.status = ST_DOUBLE;
      end
    end
    res.codeword = cw;
    res.data     = {cw[12], cw[10:8], cw[6:0]};
    res.syndrome = syn;
    return res;
  endfunction

  // Flip n distinct random bits
  function automatic logic [15:0] inject_errors(logic [15:0] cw, int unsigned n);
    logic [15:0] mask;
    mask = '0;
    while ($countones(mask) < n) mask[$urandom_range(0, 15)] = 1'b1;
    return cw ^ mask;
  endfunction

  task automatic report_mismatch(string what, int unsigned exp_val, int unsigned got_val);
    $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, exp_val, got_val);
    mismatch_count++;
  endtask

  task automatic send_item(op_e op, logic [15:0] w);
    int unsigned gap;
    gap = (bursts_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    word_in_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_codec_result(op, w));
    if (op == OP_ENCODE) n_encode++;
    else n_decode++;
  endtask

  // Receiver side backpressure
  always @(negedge clk_i) begin
    if (!bursts_on) begin
      stall_left = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, codeword", 0, codeword_out_o);
      end else begin
        exp_res = expected_results.pop_front();
        n_checked++;
        if (exp_res.status == ST_CORRECTED) n_corrected++;
        if (exp_res.status == ST_DOUBLE) n_double++;
        if (codeword_out_o !== exp_res.codeword)
          report_mismatch("codeword_out", exp_res.codeword, codeword_out_o);
        if (data_out_o !== exp_res.data)
          report_mismatch("data_out", exp_res.data, data_out_o);
        if (syndrome_o !== exp_res.syndrome)
          report_mismatch("syndrome", exp_res.syndrome, syndrome_o);
        if (status_o !== exp_res.status)
          report_mismatch("status", exp_res.status, status_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_encode_extremes();
    send_item(OP_ENCODE, 16'h0000);
    send_item(OP_ENCODE, 16'hFFFF);
    send_item(OP_ENCODE, 16'h0555);
    send_item(OP_ENCODE, 16'hFAAA);
    send_item(OP_ENCODE, 16'h0400);
  endtask

  task automatic test_decode_clean();
    send_item(OP_DECODE, encode_secded(11'h000));
    send_item(OP_DECODE, encode_secded(11'h7FF));
    send_item(OP_DECODE, 16'hFFFF);
  endtask

  // One flip at every position, parity bit 15 included
  task automatic test_single_errors();
    logic [15:0] base;
    base = encode_secded(11'h5A3);
    for (int p = 0; p < 16; p++) send_item(OP_DECODE, base ^ (16'h0001 << p));
  endtask

  task automatic test_multi_errors();
    logic [15:0] base;
    base = encode_secded(11'h2C9);
    send_item(OP_DECODE, base ^ 16'h0003);
    send_item(OP_DECODE, base ^ 16'h8001);
    send_item(OP_DECODE, base ^ 16'h0007);
  endtask

  task automatic test_random_traffic(int unsigned count);
    logic [15:0] w;
    int unsigned kind;
    for (int unsigned i = 0; i < count; i++) begin
      w    = 16'($urandom());
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: send_item(OP_ENCODE, w);
        3:       send_item(OP_DECODE, w);
        4, 5:    send_item(OP_DECODE, encode_secded(w[10:0]));
        6, 7:    send_item(OP_DECODE, inject_errors(encode_secded(w[10:0]), 1));
        8:       send_item(OP_DECODE, inject_errors(encode_secded(w[10:0]), 2));
        default: send_item(OP_DECODE, inject_errors(encode_secded(w[10:0]),
                                                    $urandom_range(3, 5)));
      endcase
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_ENCODE;
    word_in_i      = '0;
    out_ready_i    = 1'b0;
    bursts_on      = 1'b1;
    stall_left     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    n_encode       = 0;
    n_decode       = 0;
    n_checked      = 0;
    n_corrected    = 0;
    n_double       = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_encode_extremes();
    test_decode_clean();
    test_single_errors();
    test_multi_errors();
    test_random_traffic(1000);
    bursts_on = 1'b0;
    test_random_traffic(200);
    bursts_on = 1'b1;
    test_random_traffic(300);
    bursts_on = 1'b0;
    test_random_traffic(200);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d encode and %0d decode transactions, %0d results checked",
             n_encode, n_decode, n_checked);
    $display("decode outcomes: %0d corrected, %0d double errors; %0d mismatches",
             n_corrected, n_double, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: secded_16_11_codec_core.f
rtl/core/secded_pkg.sv
rtl/core/secded_enc.sv
rtl/core/secded_dec.sv
rtl/core/secded_16_11_codec_core.sv
rtl/core/secded_checker.sv
dv/tb_top.sv
